### src/wsc_pkg.sv
// Shared types, constants and helpers for the wave sound channel.
`timescale 1ns / 1ps
package wsc_pkg;

    // Pattern RAM size in bytes
    localparam int WAVE_BYTES_DEF = 16;

    // Operation codes carried on s_tuser
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_LENGTH = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_POWER  = 3'd4;

    // Register map
    localparam logic [15:0] ADDR_DAC     = 16'hff1a;
    localparam logic [15:0] ADDR_LENGTH  = 16'hff1b;
    localparam logic [15:0] ADDR_VOLUME  = 16'hff1c;
    localparam logic [15:0] ADDR_FREQ_LO = 16'hff1d;
    localparam logic [15:0] ADDR_FREQ_HI = 16'hff1e;
    localparam logic [15:0] ADDR_WAVE    = 16'hff30;

    // Fixed bits returned on reads
    localparam logic [7:0] RD_OPEN    = 8'hff;
    localparam logic [7:0] RD_DAC_ONE = 8'h7f;
    localparam logic [7:0] RD_VOL_ONE = 8'h9f;
    localparam logic [7:0] RD_HI_ONE  = 8'hbf;

    localparam logic [11:0] PERIOD_BASE = 12'd2048;
    localparam logic [8:0]  LENGTH_FULL = 9'd256;

    // One input beat
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        odd;
        logic        init_len;
    } wsc_item_t;

    // One result beat
    typedef struct packed {
        logic [3:0] sample;
        logic [7:0] rdata;
    } wsc_result_t;

    // Volume code to right shift: 0 mutes, 1 full, 2 half, 3 quarter
    function automatic logic [2:0] vol_shift(input logic [1:0] code);
        logic [2:0] sh;
        case (code)
            2'd0:    sh = 3'd4;
            2'd1:    sh = 3'd0;
            2'd2:    sh = 3'd1;
            2'd3:    sh = 3'd2;
            default: sh = 3'd4;
        endcase
        return sh;
    endfunction

endpackage

### src/wsc_core.sv
// Channel state and the single-pass update for one operation beat.
`timescale 1ns / 1ps
module wsc_core
    import wsc_pkg::*;
#(
    parameter int WAVE_BYTES = WAVE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  wsc_item_t   item,
    output wsc_result_t result
);

    localparam int AW  = $clog2(WAVE_BYTES);
    localparam int NPW = AW + 1;

    logic           channel_on_reg,    channel_on_next;
    logic           dac_on_reg,        dac_on_next;
    logic [1:0]     volume_code_reg,   volume_code_next;
    logic [10:0]    freq_value_reg,    freq_value_next;
    logic           length_enable_reg, length_enable_next;
    logic [8:0]     length_left_reg,   length_left_next;
    logic [11:0]    period_left_reg,   period_left_next;
    logic [NPW-1:0] nibble_pos_reg,    nibble_pos_next;
    logic [3:0]     held_nibble_reg,   held_nibble_next;
    logic [3:0]     out_sample_reg,    out_sample_next;
    logic [7:0]     wave_ram_reg [WAVE_BYTES];

    logic           ram_we;
    logic [AW-1:0]  ram_wa;
    logic [AW-1:0]  ram_ra;
    logic [7:0]     ram_q;
    logic [NPW-1:0] pos_inc;
    logic [3:0]     nib;
    logic [7:0]     rdata;
    logic           wave_hit;
    logic [11:0]    period_dec;
    logic [11:0]    period_reload;

    // Single RAM read port, shared by bus reads and the sample step
    assign pos_inc  = nibble_pos_reg + NPW'(1);
    assign ram_ra   = (item.op == OP_READ) ? item.addr[AW-1:0] : pos_inc[NPW-1:1];
    assign ram_q    = wave_ram_reg[ram_ra];
    assign nib      = pos_inc[0] ? ram_q[3:0] : ram_q[7:4];
    assign wave_hit = (item.addr >= ADDR_WAVE)
                   && (item.addr < (ADDR_WAVE + 16'(WAVE_BYTES)));
    assign ram_wa   = item.addr[AW-1:0];
    assign period_dec    = period_left_reg - 12'd1;
    assign period_reload = PERIOD_BASE - {1'b0, freq_value_reg};

    // Next state for the current beat
    always_comb begin
        channel_on_next    = channel_on_reg;
        dac_on_next        = dac_on_reg;
        volume_code_next   = volume_code_reg;
        freq_value_next    = freq_value_reg;
        length_enable_next = length_enable_reg;
        length_left_next   = length_left_reg;
        period_left_next   = period_left_reg;
        nibble_pos_next    = nibble_pos_reg;
        held_nibble_next   = held_nibble_reg;
        out_sample_next    = out_sample_reg;
        rdata              = RD_OPEN;
        ram_we             = 1'b0;

        if (go) begin
            case (item.op)
                OP_TICK: begin
                    if (period_left_reg != 12'd0) begin
                        period_left_next = period_dec;
                        if (period_dec == 12'd0) begin
                            period_left_next = period_reload;
                            nibble_pos_next  = pos_inc;
                            held_nibble_next = nib;
                        end
                    end
                    out_sample_next = channel_on_reg
                                    ? (held_nibble_next >> vol_shift(volume_code_reg))
                                    : 4'd0;
                end
                OP_LENGTH: begin
                    if (length_enable_reg && length_left_reg != 9'd0) begin
                        length_left_next = length_left_reg - 9'd1;
                        if (length_left_next == 9'd0) channel_on_next = 1'b0;
                    end
                end
                OP_READ: begin
                    if (item.addr == ADDR_DAC) begin
                        rdata = {dac_on_reg, 7'd0} | RD_DAC_ONE;
                    end else if (item.addr == ADDR_VOLUME) begin
                        rdata = {1'b0, volume_code_reg, 5'd0} | RD_VOL_ONE;
                    end else if (item.addr == ADDR_FREQ_HI) begin
                        rdata = {1'b0, length_enable_reg, 6'd0} | RD_HI_ONE;
                    end else if (wave_hit) begin
                        rdata = ram_q;
                    end
                end
                OP_WRITE: begin
                    if (item.addr == ADDR_DAC) begin
                        dac_on_next = item.wdata[7];
                        if (!item.wdata[7]) channel_on_next = 1'b0;
                    end else if (item.addr == ADDR_LENGTH) begin
                        length_left_next = LENGTH_FULL - {1'b0, item.wdata};
                    end else if (item.addr == ADDR_VOLUME) begin
                        volume_code_next = item.wdata[6:5];
                    end else if (item.addr == ADDR_FREQ_LO) begin
                        freq_value_next = {freq_value_reg[10:8], item.wdata};
                    end else if (item.addr == ADDR_FREQ_HI) begin
                        // Extra length clock when enabling on an odd phase
                        if (item.odd && !length_enable_reg && item.wdata[6]
                            && length_left_reg != 9'd0) begin
                            length_left_next = length_left_reg - 9'd1;
                            if (length_left_next == 9'd0) channel_on_next = 1'b0;
                        end
                        length_enable_next = item.wdata[6];
                        freq_value_next    = {item.wdata[2:0], freq_value_reg[7:0]};
                        // Trigger
                        if (item.wdata[7]) begin
                            channel_on_next  = dac_on_reg;
                            period_left_next = PERIOD_BASE - {1'b0, freq_value_next};
                            nibble_pos_next  = '0;
                            if (length_left_next == 9'd0) begin
                                length_left_next = (item.odd && item.wdata[6])
                                                 ? (LENGTH_FULL - 9'd1) : LENGTH_FULL;
                            end
                        end
                    end else if (wave_hit) begin
                        ram_we = 1'b1;
                    end
                end
                OP_POWER: begin
                    channel_on_next    = 1'b0;
                    dac_on_next        = 1'b0;
                    volume_code_next   = 2'd0;
                    freq_value_next    = 11'd0;
                    length_enable_next = 1'b0;
                    out_sample_next    = 4'd0;
                    period_left_next   = 12'd0;
                    nibble_pos_next    = '0;
                    held_nibble_next   = 4'd0;
                    if (item.init_len) length_left_next = LENGTH_FULL;
                end
                default: begin
                end
            endcase
        end
    end

    assign result.sample = out_sample_next;
    assign result.rdata  = rdata;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_on_reg    <= 1'b0;
            dac_on_reg        <= 1'b0;
            volume_code_reg   <= 2'd0;
            freq_value_reg    <= 11'd0;
            length_enable_reg <= 1'b0;
            length_left_reg   <= LENGTH_FULL;
            period_left_reg   <= 12'd0;
            nibble_pos_reg    <= '0;
            held_nibble_reg   <= 4'd0;
            out_sample_reg    <= 4'd0;
        end else begin
            channel_on_reg    <= channel_on_next;
            dac_on_reg        <= dac_on_next;
            volume_code_reg   <= volume_code_next;
            freq_value_reg    <= freq_value_next;
            length_enable_reg <= length_enable_next;
            length_left_reg   <= length_left_next;
            period_left_reg   <= period_left_next;
            nibble_pos_reg    <= nibble_pos_next;
            held_nibble_reg   <= held_nibble_next;
            out_sample_reg    <= out_sample_next;
        end
    end

    // Pattern RAM, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WAVE_BYTES; i++) wave_ram_reg[i] <= 8'd0;
        end else if (ram_we) begin
            wave_ram_reg[ram_wa] <= item.wdata;
        end
    end

endmodule

### src/wave_sound_channel.sv
// Wave sound channel top level: input register, channel core, result register.
// Path of an accepted beat: input register, core, result register, m_tdata.
// Throughput: one beat per cycle unless stalled; each operation is one core pass.
// The input register stalls only while the result register is full and unread.
// Reset (aresetn low, synchronous) empties both registers, clears the pattern
// RAM and channel state, and sets the length counter to 256.
`timescale 1ns / 1ps
module wave_sound_channel
    import wsc_pkg::*;
#(
    parameter int WAVE_BYTES = WAVE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16], phase_odd[24],
                                   // init_length[25], zero fill
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // sample[3:0], read_data[11:4], zero fill
);

    logic        in_valid_reg;
    wsc_item_t   in_item_reg;
    logic        out_valid_reg;
    wsc_result_t out_data_reg;
    wsc_result_t core_result;
    logic        advance;

    // Move the held beat through the core when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op       <= s_tuser;
            in_item_reg.addr     <= s_tdata[15:0];
            in_item_reg.wdata    <= s_tdata[23:16];
            in_item_reg.odd      <= s_tdata[24];
            in_item_reg.init_len <= s_tdata[25];
        end
    end

    wsc_core #(
        .WAVE_BYTES (WAVE_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg.rdata, out_data_reg.sample};

endmodule

### src/wsc_checker.sv
// Port-level checks for the wave sound channel, bound to the top level.
`timescale 1ns / 1ps
module wsc_port_checks
    import wsc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat shown right after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Input side stalls only behind a full, unread result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // A beat that is not a bus read returns open-bus read data
    a_nonread_ff: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != OP_READ) ##1 m_tready
        |=> m_tdata[11:4] == RD_OPEN)
        else $error("non-read beat returned read data");

    // Power-up silences the channel
    a_power_mute: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_POWER) ##1 m_tready
        |=> m_tdata[3:0] == 4'd0)
        else $error("sample not zero after power-up");

endmodule

bind wave_sound_channel wsc_port_checks u_wsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/wsc_checker.sv
// Checker for the wave sound channel: predicts every result beat and compares it.
`timescale 1ns / 1ps
module wsc_checker
    import wsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16], phase_odd[24],
                                   // init_length[25], zero fill
    input  logic [2:0]  s_tuser,   // operation[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // sample[3:0], read_data[11:4], zero fill
    output int          mismatches,
    output int          outstanding
);

    // Predicted channel state
    logic        ch_on;
    logic        dac_en;
    logic [1:0]  vol_code;
    logic [10:0] freq;
    logic        len_en;
    logic [7:0]  pattern [WAVE_BYTES_DEF];
    logic [8:0]  len_left;
    logic [11:0] period_left;
    logic [4:0]  pos;
    logic [3:0]  held;
    logic [3:0]  cur_sample;

    wsc_result_t pending_results [$];
    int          err_cnt = 0;

    // High nibble of each byte comes first
    function automatic logic [3:0] nibble_of(input logic [4:0] p);
        return p[0] ? pattern[p[4:1]][3:0] : pattern[p[4:1]][7:4];
    endfunction

    function automatic void clock_length();
        if (len_left != 9'd0) begin
            len_left = len_left - 9'd1;
            if (len_left == 9'd0) ch_on = 1'b0;
        end
    endfunction

    // Power-up: everything but the pattern RAM, length only on request
    function automatic void power_cycle(input logic init_len);
        ch_on       = 1'b0;
        dac_en      = 1'b0;
        vol_code    = 2'd0;
        freq        = 11'd0;
        len_en      = 1'b0;
        cur_sample  = 4'd0;
        period_left = 12'd0;
        pos         = 5'd0;
        held        = 4'd0;
        if (init_len) len_left = LENGTH_FULL;
    endfunction

    function automatic void reset_channel();
        for (int i = 0; i < WAVE_BYTES_DEF; i++) pattern[i] = 8'h00;
        len_left = LENGTH_FULL;
        power_cycle(1'b0);
    endfunction

    function automatic logic [7:0] reg_read(input logic [15:0] a);
        if (a == ADDR_DAC) return {dac_en, 7'h7f};
        if (a == ADDR_VOLUME) return {1'b1, vol_code, 5'h1f};
        if (a == ADDR_FREQ_HI) return {1'b1, len_en, 6'h3f};
        if (a[15:4] == ADDR_WAVE[15:4]) return pattern[a[3:0]];
        return RD_OPEN;
    endfunction

    function automatic void reg_write(input logic [15:0] a, input logic [7:0] d,
                                      input logic odd);
        if (a == ADDR_DAC) begin
            dac_en = d[7];
            if (!dac_en) ch_on = 1'b0;
        end else if (a == ADDR_LENGTH) begin
            len_left = LENGTH_FULL - {1'b0, d};
        end else if (a == ADDR_VOLUME) begin
            vol_code = d[6:5];
        end else if (a == ADDR_FREQ_LO) begin
            freq[7:0] = d;
        end else if (a == ADDR_FREQ_HI) begin
            // enabling length on an odd phase clocks it once
            if (odd && !len_en && d[6]) clock_length();
            len_en     = d[6];
            freq[10:8] = d[2:0];
            if (d[7]) begin
                ch_on       = dac_en;
                period_left = PERIOD_BASE - {1'b0, freq};
                pos         = 5'd0;
                if (len_left == 9'd0) len_left = (odd && len_en) ? 9'd255 : LENGTH_FULL;
            end
        end else if (a[15:4] == ADDR_WAVE[15:4]) begin
            pattern[a[3:0]] = d;
        end
    endfunction

    function automatic void sample_step();
        logic [3:0] s;
        if (period_left != 12'd0) begin
            period_left = period_left - 12'd1;
            if (period_left == 12'd0) begin
                period_left = PERIOD_BASE - {1'b0, freq};
                pos         = pos + 5'd1;
                held        = nibble_of(pos);
            end
        end
        case (vol_code)
            2'd0:    s = 4'd0;
            2'd1:    s = held;
            2'd2:    s = held >> 1;
            default: s = held >> 2;
        endcase
        cur_sample = ch_on ? s : 4'd0;
    endfunction

    // One input beat through the predicted channel
    function automatic wsc_result_t channel_step(input wsc_item_t it);
        wsc_result_t res;
        res.rdata = RD_OPEN;
        case (it.op)
            OP_TICK:   sample_step();
            OP_LENGTH: if (len_en) clock_length();
            OP_READ:   res.rdata = reg_read(it.addr);
            OP_WRITE:  reg_write(it.addr, it.wdata, it.odd);
            OP_POWER:  power_cycle(it.init_len);
            default:   ;
        endcase
        res.sample = cur_sample;
        return res;
    endfunction

    // Watch both channels; results are compared before the new input is predicted
    always @(posedge aclk) begin : watch
        wsc_item_t   item;
        wsc_result_t got;
        wsc_result_t want;
        if (!aresetn) begin
            reset_channel();
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.sample = m_tdata[3:0];
                got.rdata  = m_tdata[11:4];
                if (pending_results.size() == 0) begin
                    $error("unexpected result beat: sample %0d read_data 0x%02h",
                           got.sample, got.rdata);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.sample !== want.sample) begin
                        $error("sample: expected %0d, actual %0d", want.sample, got.sample);
                        err_cnt++;
                    end
                    if (got.rdata !== want.rdata) begin
                        $error("read_data: expected 0x%02h, actual 0x%02h",
                               want.rdata, got.rdata);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                item.op       = s_tuser;
                item.addr     = s_tdata[15:0];
                item.wdata    = s_tdata[23:16];
                item.odd      = s_tdata[24];
                item.init_len = s_tdata[25];
                pending_results.push_back(channel_step(item));
            end
        end
        mismatches  <= err_cnt;
        outstanding <= pending_results.size();
    end

endmodule

### dv/tb_top.sv
// Testbench top for the wave sound channel: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import wsc_pkg::*;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;
    logic [2:0]  s_tuser  = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int mismatches;
    int outstanding;
    bit calm = 1'b0;
    int ready_hold = 0;

    wave_sound_channel uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wsc_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver back-pressure; stays ready through calm stretches
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold--;
        end else if (calm || !m_tready) begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 20);
        end else begin
            m_tready <= 1'b0;
            ready_hold = idle_len();
        end
    end

    // Drive one beat, hold it until accepted, then maybe idle
    task automatic push_op(input logic [2:0] op, input logic [15:0] addr,
                           input logic [7:0] wd, input logic odd, input logic il);
        int g;
        s_tuser  <= op;
        s_tdata  <= {6'd0, il, odd, wd, addr};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        g = calm ? 0 : idle_len();
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Mostly mapped registers, sometimes any address
    function automatic logic [15:0] pick_reg_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'($urandom_range(0, 65535));
        if (r < 20) return ADDR_DAC;
        if (r < 30) return ADDR_LENGTH;
        if (r < 40) return ADDR_VOLUME;
        if (r < 52) return ADDR_FREQ_LO;
        if (r < 70) return ADDR_FREQ_HI;
        return ADDR_WAVE + 16'($urandom_range(0, 15));
    endfunction

    task automatic random_op();
        int          r;
        logic [15:0] a;
        logic [7:0]  d;
        logic        odd;
        logic        il;
        r   = $urandom_range(0, 99);
        a   = 16'($urandom_range(0, 65535));
        d   = 8'($urandom_range(0, 255));
        odd = 1'($urandom_range(0, 1));
        il  = 1'($urandom_range(0, 1));
        if (r < 38) begin
            push_op(OP_TICK, a, d, odd, il);
        end else if (r < 48) begin
            push_op(OP_LENGTH, a, d, odd, il);
        end else if (r < 62) begin
            push_op(OP_READ, pick_reg_addr(), d, odd, il);
        end else if (r < 97) begin
            // bias toward a running channel with a short period
            a = pick_reg_addr();
            if (a == ADDR_DAC && $urandom_range(0, 4) != 0) d[7] = 1'b1;
            if (a == ADDR_FREQ_LO && $urandom_range(0, 2) != 0) d[7:4] = 4'hf;
            if (a == ADDR_FREQ_HI && $urandom_range(0, 2) != 0) d[2:0] = 3'b111;
            push_op(OP_WRITE, a, d, odd, il);
        end else if (r < 99) begin
            push_op(3'($urandom_range(5, 7)), a, d, odd, il);
        end else begin
            push_op(OP_POWER, a, d, odd, il);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reads after reset, including unmapped addresses
        push_op(OP_READ, ADDR_DAC, 8'h00, 1'b0, 1'b0);
        push_op(OP_READ, ADDR_LENGTH, 8'h00, 1'b0, 1'b0);
        push_op(OP_READ, ADDR_VOLUME, 8'h00, 1'b0, 1'b0);
        push_op(OP_READ, ADDR_FREQ_LO, 8'h00, 1'b0, 1'b0);
        push_op(OP_READ, 16'hffff, 8'hff, 1'b1, 1'b1);
        // Tick with the period stopped
        push_op(OP_TICK, 16'h0000, 8'h00, 1'b0, 1'b0);
        // Pattern RAM at both ends, DAC on, volume with bit 7 set
        push_op(OP_WRITE, ADDR_WAVE, 8'h1f, 1'b0, 1'b0);
        push_op(OP_WRITE, ADDR_WAVE + 16'd15, 8'hff, 1'b0, 1'b0);
        push_op(OP_WRITE, ADDR_DAC, 8'h80, 1'b0, 1'b0);
        push_op(OP_WRITE, ADDR_VOLUME, 8'hff, 1'b0, 1'b0);
        push_op(OP_WRITE, ADDR_FREQ_LO, 8'hff, 1'b0, 1'b0);
        // Length 1, extra clock on odd phase takes it to zero, then trigger
        push_op(OP_WRITE, ADDR_LENGTH, 8'hff, 1'b0, 1'b0);
        push_op(OP_WRITE, ADDR_FREQ_HI, 8'h47, 1'b1, 1'b0);
        push_op(OP_WRITE, ADDR_FREQ_HI, 8'hc7, 1'b1, 1'b0);
        push_op(OP_TICK, 16'h0000, 8'h00, 1'b0, 1'b0);
        push_op(OP_TICK, 16'h0000, 8'h00, 1'b0, 1'b0);
        push_op(OP_LENGTH, 16'h0000, 8'h00, 1'b0, 1'b0);
        push_op(OP_READ, ADDR_FREQ_HI, 8'h00, 1'b0, 1'b0);
        push_op(OP_READ, ADDR_WAVE + 16'd15, 8'h00, 1'b0, 1'b0);
        // Unknown codes and unmapped writes
        push_op(3'd5, ADDR_DAC, 8'h00, 1'b0, 1'b1);
        push_op(3'd7, ADDR_WAVE, 8'h00, 1'b1, 1'b1);
        push_op(OP_WRITE, 16'hff2f, 8'haa, 1'b0, 1'b0);
        push_op(OP_WRITE, 16'hff40, 8'h55, 1'b0, 1'b0);
        // Power-up keeping and then reloading the length
        push_op(OP_POWER, 16'h0000, 8'h00, 1'b0, 1'b0);
        push_op(OP_POWER, 16'h0000, 8'h00, 1'b0, 1'b1);

        // Random traffic with calm stretches
        for (int i = 0; i < 1100; i++) begin
            calm = ((i / 100) % 5) == 4;
            random_op();
        end
        s_tvalid <= 1'b0;
        calm = 1'b1;

        // Drain and allow for the pipeline
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
